/* src/bsh32_pkg.sv */
// ----------------------------------------------------------------------------
// bsh32_pkg
// Shared types and constants for the byte string hash unit.
// ----------------------------------------------------------------------------
package bsh32_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned RemW  = 24;
  localparam int unsigned HashW = 32;

  localparam logic [RemW-1:0] HashModulus = 24'd16777213;

  localparam logic KindAppend = 1'b0;
  localparam logic KindFinish = 1'b1;

  typedef struct packed {
    logic             fire;
    logic             finish;
    logic [ByteW-1:0] data;
  } step_t;

  typedef struct packed {
    logic [RemW-1:0]  remainder;
    logic [ByteW-1:0] parity;
  } hash_state_t;

endpackage

/* src/bsh32_if.sv */
// ----------------------------------------------------------------------------
// bsh32 channel interfaces
// Valid/ready channels for the input beats and the hash result beats.
// ----------------------------------------------------------------------------
interface bsh32_in_if;
  logic                      valid;
  logic                      ready;
  logic                      kind;
  logic [bsh32_pkg::ByteW-1:0] data_byte;

  modport source (output valid, output kind, output data_byte, input ready);
  modport sink   (input valid, input kind, input data_byte, output ready);
endinterface

interface bsh32_out_if;
  logic                        valid;
  logic                        ready;
  logic [bsh32_pkg::HashW-1:0] hash_value;

  modport source (output valid, output hash_value, input ready);
  modport sink   (input valid, input hash_value, output ready);
endinterface

/* src/bsh32_core.sv */
// ----------------------------------------------------------------------------
// bsh32_core
// Hash state: remainder mod 2^24-3 folded as low + 3*high, plus byte XOR.
// ----------------------------------------------------------------------------
module bsh32_core (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  bsh32_pkg::step_t       step_i,
  output bsh32_pkg::hash_state_t state_o
);

  logic [bsh32_pkg::RemW-1:0]  rem_q, rem_d;
  logic [bsh32_pkg::ByteW-1:0] par_q, par_d;
  logic [bsh32_pkg::HashW-1:0] inter;
  logic [bsh32_pkg::RemW:0]    fold;
  logic [bsh32_pkg::RemW:0]    diff;
  logic [bsh32_pkg::RemW-1:0]  rem_red;

  always_comb begin
    // data byte MSB set: intermediate is the sign-extended byte, remainder unused
    if (step_i.data[bsh32_pkg::ByteW-1]) begin
      inter = {{bsh32_pkg::RemW{1'b1}}, step_i.data};
    end else begin
      inter = {rem_q, step_i.data};
    end
    fold = 25'(inter[bsh32_pkg::RemW-1:0])
         + 25'(inter[bsh32_pkg::HashW-1:bsh32_pkg::RemW])
         + 25'({inter[bsh32_pkg::HashW-1:bsh32_pkg::RemW], 1'b0});
    diff = fold - {1'b0, bsh32_pkg::HashModulus};
    // borrow means fold already below modulus
    rem_red = diff[bsh32_pkg::RemW] ? fold[bsh32_pkg::RemW-1:0]
                                    : diff[bsh32_pkg::RemW-1:0];
  end

  always_comb begin
    rem_d = rem_q;
    par_d = par_q;
    if (step_i.fire) begin
      if (step_i.finish) begin
        rem_d = '0;
        par_d = '0;
      end else begin
        rem_d = rem_red;
        par_d = par_q ^ step_i.data;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q <= '0;
      par_q <= '0;
    end else begin
      rem_q <= rem_d;
      par_q <= par_d;
    end
  end

  assign state_o.remainder = rem_q;
  assign state_o.parity    = par_q;

endmodule

/* src/byte_string_hash32_unit.sv */
// ----------------------------------------------------------------------------
// byte_string_hash32_unit
// Streaming base-256 rolling hash of a byte string, modulo 2^24-3.
// A finish beat sits in s1 until out_o is free; its hash fills out_hash_q.
// One beat per cycle unless out_o holds a finish; one fold-and-subtract stage.
// Reset: rst_ni low clears remainder, parity and all valid flags at once.
// ----------------------------------------------------------------------------
module byte_string_hash32_unit (
  input  logic              clk_i,
  input  logic              rst_ni,
  bsh32_in_if.sink          in_i,
  bsh32_out_if.source       out_o
);

  logic                          s1_valid_q;
  logic                          s1_kind_q;
  logic [bsh32_pkg::ByteW-1:0]   s1_byte_q;
  logic                          out_valid_q;
  logic [bsh32_pkg::HashW-1:0]   out_hash_q;
  logic                          out_free;
  logic                          s1_adv;
  logic                          in_fire;
  bsh32_pkg::step_t              step;
  bsh32_pkg::hash_state_t        state;

  assign out_free    = !out_valid_q || out_o.ready;
  assign s1_adv      = s1_valid_q && (s1_kind_q == bsh32_pkg::KindAppend || out_free);
  assign in_i.ready  = !s1_valid_q || s1_adv;
  assign in_fire     = in_i.valid && in_i.ready;

  assign step.fire   = s1_adv;
  assign step.finish = (s1_kind_q == bsh32_pkg::KindFinish);
  assign step.data   = s1_byte_q;

  bsh32_core u_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (step),
    .state_o (state)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_fire) begin
        s1_valid_q <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_adv && step.finish) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_kind_q <= in_i.kind;
      s1_byte_q <= in_i.data_byte;
    end
    if (s1_adv && step.finish) begin
      out_hash_q <= {state.parity, state.remainder};
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.hash_value = out_hash_q;

`ifndef SYNTHESIS
  a_rem_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state.remainder < bsh32_pkg::HashModulus)
    else $error("remainder out of range");

  a_finish_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_adv && step.finish) |=> (state.remainder == '0 && state.parity == '0))
    else $error("finish did not clear hash state");

  a_finish_emits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_adv && step.finish) |=> out_valid_q)
    else $error("finish beat produced no result");

  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && step.finish && out_valid_q && !out_o.ready) |-> !in_i.ready)
    else $error("input taken while finish beat blocked");
`endif

endmodule
